// ===== src/affine_stereographic_projector_unit_macros.svh =====
// Assertion macros shared by the projector RTL.
`ifndef AFFINE_STEREOGRAPHIC_PROJECTOR_UNIT_MACROS_SVH
`define AFFINE_STEREOGRAPHIC_PROJECTOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASP_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASP_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define ASP_ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define ASP_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg)
`endif
`endif

// ===== src/asp_pkg.sv =====
// Package with shared types and constants of the stereographic projector.
package asp_pkg;

    localparam int unsigned COEF_W  = 20;
    localparam int unsigned ROW_W   = 60;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned CFG_IDX_W = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Z = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    // Control bundle from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_start;
        logic finish;
    } t_ctrl;

    typedef struct packed {
        logic signed [31:0] proj_x;
        logic signed [31:0] proj_y;
        logic signed [31:0] box_xmin;
        logic signed [31:0] box_ymin;
        logic [30:0]        box_xmax;
        logic [30:0]        box_ymax;
        logic               pole_hit;
        logic               last_out;
    } t_result;

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic               last_vertex;
    } t_vertex;

endpackage

// ===== src/asp_if.sv =====
// Valid/ready channel interface carrying one payload.
interface asp_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/asp_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, on magnitudes.
module asp_div #(
    parameter int unsigned NUM_W = 68,
    parameter int unsigned DEN_W = 36,
    parameter int unsigned Q_W   = 34
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot,
    output logic             o_ovf
);
    localparam int unsigned CNT_W = $clog2(Q_W + 1);

    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [Q_W-1:0]   r_quot, n_quot;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_ovf, n_ovf;
    logic             r_done;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W+1:0] w_diff;

    // Shift one numerator bit into the partial remainder and try subtracting.
    always_comb begin
        w_trial = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_den};
        n_num   = r_num;
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_ovf   = r_ovf;
        if (i_start) begin
            n_num  = i_num;
            n_rem  = '0;
            n_quot = '0;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
            n_ovf  = 1'b0;
        end else if (r_busy) begin
            n_num = {r_num[NUM_W-2:0], 1'b0};
            if (!w_diff[DEN_W+1] || r_rem[DEN_W]) begin
                n_rem = w_diff[DEN_W:0];
                if (r_quot[Q_W-1]) n_ovf = 1'b1;
                n_quot = {r_quot[Q_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                if (r_quot[Q_W-1]) n_ovf = 1'b1;
                n_quot = {r_quot[Q_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= r_busy && (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) r_den <= i_den;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_ovf  <= n_ovf;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;
endmodule

// ===== src/asp_ctrl.sv =====
// Sequencer of the projector: transform, divide and hand-off phases.
module asp_ctrl
    import asp_pkg::*;
#(
    parameter int unsigned MUL_CYC = 3
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_xfer,
    input  logic  i_div_done,
    input  logic  i_out_free,
    output logic  o_in_ready,
    output t_ctrl o_ctrl
);
    localparam int unsigned CNT_W = $clog2(MUL_CYC + 1);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_xfer) n_state = ST_MUL;
            ST_MUL:  if (r_cnt == CNT_W'(MUL_CYC - 1)) n_state = ST_DIV;
            ST_DIV:  if (i_div_done) n_state = ST_DONE;
            ST_DONE: if (i_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready       = 1'b0;
        o_ctrl           = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_ctrl.load   = i_in_xfer;
            end
            ST_MUL: begin
                o_ctrl.mul_step  = 1'b1;
                o_ctrl.div_start = (r_cnt == CNT_W'(MUL_CYC - 1));
            end
            ST_DIV: ;
            ST_DONE: o_ctrl.finish = i_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MUL) r_cnt <= r_cnt + 1'b1;
            else r_cnt <= '0;
        end
    end
endmodule

// ===== src/affine_stereographic_projector_unit.sv =====
// Top level of the affine stereographic projector.
//  channel | dir | payload                                  | transfer when
//  in_ch   | in  | vert_x/y/z, last_vertex                  | valid && ready
//  out_ch  | out | proj_x/y, box min/max, pole_hit, last_out| valid && ready
//  cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data          | i_cfg_we
// One vertex at a time, with no output stall: an idle step that accepts it,
// the transform steps (one product row per cycle through the shared multipliers),
// the divider steps (radix-2, x and y in parallel, one quotient bit per cycle
// plus a done step) and a result step. The input is not ready again until the
// vertex has passed the result step; while an earlier result still waits in the
// result register the sequencer holds and the input stays not ready.
// Reset is synchronous and clears control state and the bounding box.
`include "affine_stereographic_projector_unit_macros.svh"
module affine_stereographic_projector_unit
    import asp_pkg::*;
#(
    parameter int unsigned COORD_FRAC_BITS = 16,
    parameter int unsigned COEF_FRAC_BITS  = 18
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ROW_W-1:0]     i_cfg_data,
    asp_if.sink                  in_ch,
    asp_if.source                out_ch
);
    // The transformed coordinate grows as the coefficient fraction shrinks.
    localparam int unsigned F_W   = 53 - COEF_FRAC_BITS;
    localparam int unsigned DEN_W = F_W + 1;
    localparam int unsigned NUM_W = F_W + 1 + COORD_FRAC_BITS;
    localparam int unsigned Q_W   = NUM_W;
    localparam int unsigned S_W   = 55;

    logic [ROW_W-1:0] r_row_x, r_row_y, r_row_z;
    logic signed [COORD_W-1:0] r_off_x, r_off_y, r_off_z;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x <= ROW_W'(1) << (2 * COEF_W + COEF_FRAC_BITS);
            r_row_y <= ROW_W'(1) << (COEF_W + COEF_FRAC_BITS);
            r_row_z <= ROW_W'(1) << COEF_FRAC_BITS;
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW_X: r_row_x <= i_cfg_data;
                REG_ROW_Y: r_row_y <= i_cfg_data;
                REG_ROW_Z: r_row_z <= i_cfg_data;
                REG_OFF_X: r_off_x <= i_cfg_data[COORD_W-1:0];
                REG_OFF_Y: r_off_y <= i_cfg_data[COORD_W-1:0];
                REG_OFF_Z: r_off_z <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    t_ctrl w_ctrl;
    logic  w_div_done_x, w_div_done_y;
    logic  r_out_valid;
    logic  w_out_free;
    logic  w_in_xfer;

    assign w_out_free = !r_out_valid || out_ch.ready;
    assign w_in_xfer  = in_ch.valid && in_ch.ready;

    asp_ctrl #(.MUL_CYC(3)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_xfer  (w_in_xfer),
        .i_div_done (w_div_done_x),
        .i_out_free (w_out_free),
        .o_in_ready (in_ch.ready),
        .o_ctrl     (w_ctrl)
    );

    // Vertex latch and row sequencing: one row of three products per cycle.
    t_vertex r_vtx;
    logic [1:0] r_row_sel;
    logic signed [F_W-1:0] r_xf, r_yf;
    logic [ROW_W-1:0] w_row;
    logic signed [COORD_W-1:0] w_off;
    logic signed [S_W-1:0] w_sum;
    logic signed [F_W-1:0] w_f;

    always_comb begin
        case (r_row_sel)
            2'd0: begin w_row = r_row_x; w_off = r_off_x; end
            2'd1: begin w_row = r_row_y; w_off = r_off_y; end
            default: begin w_row = r_row_z; w_off = r_off_z; end
        endcase
        w_sum = S_W'($signed(w_row[59:40])) * S_W'(r_vtx.vert_x)
              + S_W'($signed(w_row[39:20])) * S_W'(r_vtx.vert_y)
              + S_W'($signed(w_row[19:0]))  * S_W'(r_vtx.vert_z);
        w_f = F_W'(w_sum >>> COEF_FRAC_BITS) + F_W'(w_off);
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load) begin
            r_vtx     <= in_ch.data;
            r_row_sel <= 2'd0;
        end else if (w_ctrl.mul_step) begin
            r_row_sel <= r_row_sel + 2'd1;
            case (r_row_sel)
                2'd0: r_xf <= w_f;
                2'd1: r_yf <= w_f;
                default: ;
            endcase
        end
    end

    // Divider operands, taken as zf is being produced.
    logic signed [DEN_W-1:0] w_d;
    logic [DEN_W-1:0] w_dm;
    logic [NUM_W-1:0] w_nxm, w_nym;
    logic signed [DEN_W-1:0] r_d;
    logic [Q_W-1:0] w_qx, w_qy;
    logic w_ovx, w_ovy;

    assign w_d   = DEN_W'(w_f) + (DEN_W'(1) <<< COORD_FRAC_BITS);
    assign w_dm  = w_d[DEN_W-1] ? DEN_W'(-w_d) : DEN_W'(w_d);
    assign w_nxm = NUM_W'(r_xf[F_W-1] ? DEN_W'(-DEN_W'(r_xf)) : DEN_W'(r_xf))
                   << (COORD_FRAC_BITS + 1);
    assign w_nym = NUM_W'(r_yf[F_W-1] ? DEN_W'(-DEN_W'(r_yf)) : DEN_W'(r_yf))
                   << (COORD_FRAC_BITS + 1);

    always_ff @(posedge i_clk) begin
        if (w_ctrl.div_start) r_d <= w_d;
    end

    asp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_ctrl.div_start),
        .i_num (w_nxm), .i_den (w_dm),
        .o_done (w_div_done_x), .o_quot (w_qx), .o_ovf (w_ovx)
    );
    asp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_ctrl.div_start),
        .i_num (w_nym), .i_den (w_dm),
        .o_done (w_div_done_y), .o_quot (w_qy), .o_ovf (w_ovy)
    );

    // Sign, saturation and pole handling of one coordinate.
    function automatic logic [32:0] sat_q(input logic signed [F_W-1:0] num,
                                          input logic d_neg, input logic d_zero,
                                          input logic [Q_W-1:0] q, input logic ovf);
        logic neg;
        logic [32:0] res;
        neg = num[F_W-1] ^ d_neg;
        if (num == '0) res = '0;
        else if (d_zero) res = num[F_W-1] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
        else if (neg) begin
            if (ovf || q > Q_W'(33'h8000_0000)) res = {1'b1, 32'h8000_0000};
            else res = {1'b0, 32'(-q)};
        end else begin
            if (ovf || q > Q_W'(32'h7FFF_FFFF)) res = {1'b1, 32'h7FFF_FFFF};
            else res = {1'b0, q[31:0]};
        end
        return res;
    endfunction

    logic [32:0] w_sx, w_sy;
    logic w_dz;
    assign w_dz = (r_d == '0);
    assign w_sx = sat_q(r_xf, r_d[DEN_W-1], w_dz, w_qx, w_ovx);
    assign w_sy = sat_q(r_yf, r_d[DEN_W-1], w_dz, w_qy, w_ovy);

    // Bounding box and result register.
    logic signed [31:0] r_bxmin, r_bymin, r_bxmax, r_bymax;
    logic signed [31:0] w_bxmin, w_bymin, w_bxmax, w_bymax, w_px, w_py;
    t_result r_res;
    logic r_ready_res;

    assign w_px = $signed(w_sx[31:0]);
    assign w_py = $signed(w_sy[31:0]);
    assign w_bxmin = (w_px < r_bxmin) ? w_px : r_bxmin;
    assign w_bymin = (w_py < r_bymin) ? w_py : r_bymin;
    assign w_bxmax = (w_px > r_bxmax) ? w_px : r_bxmax;
    assign w_bymax = (w_py > r_bymax) ? w_py : r_bymax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bxmin <= '0; r_bymin <= '0; r_bxmax <= '0; r_bymax <= '0;
            r_out_valid <= 1'b0;
            r_ready_res <= 1'b0;
        end else begin
            if (w_div_done_x) r_ready_res <= 1'b1;
            if (w_ctrl.finish) begin
                r_ready_res <= 1'b0;
                r_out_valid <= 1'b1;
                if (r_vtx.last_vertex) begin
                    r_bxmin <= '0; r_bymin <= '0; r_bxmax <= '0; r_bymax <= '0;
                end else begin
                    r_bxmin <= w_bxmin; r_bymin <= w_bymin;
                    r_bxmax <= w_bxmax; r_bymax <= w_bymax;
                end
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.finish) begin
            r_res.proj_x   <= w_px;
            r_res.proj_y   <= w_py;
            r_res.box_xmin <= w_bxmin;
            r_res.box_ymin <= w_bymin;
            r_res.box_xmax <= w_bxmax[30:0];
            r_res.box_ymax <= w_bymax[30:0];
            r_res.pole_hit <= w_sx[32] | w_sy[32] | w_dz;
            r_res.last_out <= r_vtx.last_vertex;
        end
    end

    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_res;

    `ASP_ASSERT_IMPL(a_div_sync, i_clk, i_rst_n, (w_div_done_x == w_div_done_y), "dividers out of step")
    `ASP_ASSERT_NEXT(a_fin_valid, i_clk, i_rst_n, w_ctrl.finish, r_out_valid, "result lost")
    `ASP_ASSERT_IMPL(a_fin_ready, i_clk, i_rst_n, (!w_ctrl.finish || r_ready_res), "result before divide")
    `ASP_ASSERT_IMPL(a_box_sign, i_clk, i_rst_n, (!r_bxmin[31] || !r_bxmax[31] && r_bxmin <= 0), "box sign")
endmodule
